>>> src/hpd_pkg.sv
// hpd_pkg: shared types, constants and helpers for the heading PID drive.
// No dependencies; used by every module under src.
package hpd_pkg;

    localparam int MUL_A_W   = 56;
    localparam int MUL_B_W   = 32;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int DIV_N_W   = 56;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);
    localparam int SUM_W     = 50;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_TARGET = 3'd1;
    localparam logic [2:0] CFG_SPEED  = 3'd2;
    localparam logic [2:0] CFG_GAIN_P = 3'd3;
    localparam logic [2:0] CFG_GAIN_I = 3'd4;
    localparam logic [2:0] CFG_GAIN_D = 3'd5;

    localparam logic MODE_HOLD = 1'b0;
    localparam logic MODE_TURN = 1'b1;

    localparam logic [3:0] FWD_ALL   = 4'd15;
    localparam logic [3:0] FWD_RIGHT = 4'd5;
    localparam logic [3:0] FWD_LEFT  = 4'd10;

    localparam logic [15:0] WRAP_DEG   = 16'd360;
    localparam logic [15:0] DT_DEFAULT = 16'd10;
    localparam logic [15:0] MILLI      = 16'd1000;

    localparam logic [23:0] GAIN_P_RST = 24'd65536;
    localparam logic [23:0] GAIN_I_RST = 24'd655;
    localparam logic [23:0] GAIN_D_RST = 24'd6554;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_CHECK,
        S_MUL_ED,
        S_MUL_P,
        S_MUL_I,
        S_DIV_I,
        S_MUL_D,
        S_MUL_K,
        S_DIV_D,
        S_SUM,
        S_FIN
    } hpd_state_t;

    typedef struct packed {
        logic signed [15:0] angle_z;
        logic [15:0]        elapsed_ms;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic signed [15:0] correction;
        logic [7:0]         motor1_duty;
        logic [7:0]         motor2_duty;
        logic [7:0]         motor3_duty;
        logic [7:0]         motor4_duty;
        logic [3:0]         motor_forward;
        logic               reached;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    function automatic logic [7:0] duty_sat(input logic signed [17:0] v);
        logic [7:0] r;
        if (v < 18'sd0)
            r = 8'd0;
        else if (v > 18'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

>>> src/hpd_mul.sv
// hpd_mul: shift-add multiplier, one multiplier bit per cycle.
// Depends on hpd_pkg (widths, mul_req_t).
module hpd_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hpd_pkg::mul_req_t           req,
    output logic [hpd_pkg::MUL_A_W-1:0] prod,
    output logic                        done
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [hpd_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [hpd_pkg::MUL_A_W-1:0]   acc_reg;
    logic [hpd_pkg::MUL_A_W-1:0]   mcand_reg;
    logic [hpd_pkg::MUL_B_W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hpd_pkg::MUL_CNT_W'(hpd_pkg::MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= req.a;
            mplier_reg <= req.b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[hpd_pkg::MUL_A_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[hpd_pkg::MUL_B_W-1:1]};
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

>>> src/hpd_div.sv
// hpd_div: restoring divider, one quotient bit per cycle.
// Depends on hpd_pkg (widths, div_req_t).
module hpd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hpd_pkg::div_req_t           req,
    output logic [hpd_pkg::DIV_N_W-1:0] quo,
    output logic [hpd_pkg::DIV_D_W-1:0] rem,
    output logic                        done
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [hpd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [hpd_pkg::DIV_N_W-1:0]   quo_reg;
    logic [hpd_pkg::DIV_D_W-1:0]   rem_reg;
    logic [hpd_pkg::DIV_D_W-1:0]   den_reg;
    logic [hpd_pkg::DIV_D_W:0]     shifted;
    logic [hpd_pkg::DIV_D_W:0]     trial;
    logic                          fits;

    // trial subtract of the divisor from the partial remainder
    assign shifted = {rem_reg, quo_reg[hpd_pkg::DIV_N_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = !trial[hpd_pkg::DIV_D_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hpd_pkg::DIV_CNT_W'(hpd_pkg::DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[hpd_pkg::DIV_D_W-1:0] : shifted[hpd_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[hpd_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

>>> src/heading_pid_drive_unit.sv
// heading_pid_drive_unit: heading PID regulator with four-wheel duty mixing.
// Depends on hpd_pkg, hpd_mul and hpd_div.
// Each item runs five serial multiplies and two serial divides, plus a wrap divide when the
//   heading magnitude exceeds 360; turn mode on target goes from the check straight to the result.
// Throughput: one transaction at a time; the next item is taken the cycle after the result
//   register loads. Reset: rst_n clears control, integral, last error and config (default gains).
module heading_pid_drive_unit (
    input  logic             clk,
    input  logic             rst_n,
    // input transactions
    input  logic             item_valid,
    output logic             item_stall,
    input  hpd_pkg::item_t   item,
    // result transactions
    output logic             result_valid,
    input  logic             result_stall,
    output hpd_pkg::result_t result,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data
);

    // ---------------- configuration registers ----------------
    logic               mode_reg;
    logic signed [9:0]  target_reg;
    logic [7:0]         speed_reg;
    logic [23:0]        gain_p_reg;
    logic [23:0]        gain_i_reg;
    logic [23:0]        gain_d_reg;

    // ---------------- regulator state ----------------
    logic signed [31:0] integ_reg;
    logic signed [10:0] last_err_reg;

    // ---------------- sequencer ----------------
    hpd_pkg::hpd_state_t state_reg, state_next;
    logic                phase_reg, phase_next;

    // ---------------- per-transaction working registers ----------------
    logic [15:0]                       mag_reg;
    logic                              hneg_reg;
    logic [15:0]                       dt_reg;
    logic signed [10:0]                heading_reg;
    logic signed [10:0]                err_reg;
    logic                              reached_reg;
    logic signed [hpd_pkg::SUM_W-1:0]  p_reg, i_reg, d_reg, sum_reg;
    logic [hpd_pkg::MUL_A_W-1:0]       tmp_reg;

    hpd_pkg::result_t result_reg;
    logic             result_valid_reg;

    // ---------------- shared arithmetic units ----------------
    hpd_pkg::mul_req_t           mul_req;
    logic [hpd_pkg::MUL_A_W-1:0] mul_prod;
    logic                        mul_done;
    hpd_pkg::div_req_t           div_req;
    logic [hpd_pkg::DIV_N_W-1:0] div_quo;
    logic [hpd_pkg::DIV_D_W-1:0] div_rem;
    logic                        div_done;

    hpd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    hpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // ---------------- handshakes ----------------
    logic item_take, fin_load;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != hpd_pkg::S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign fin_load     = (state_reg == hpd_pkg::S_FIN) && (!result_valid_reg || !result_stall);

    // ---------------- input conditioning ----------------
    // heading = -angle; keep magnitude and sign, wrap the magnitude later
    logic signed [16:0] ang_ext, ang_neg;
    logic [15:0]        in_mag;
    logic               in_hneg;
    logic [15:0]        in_dt;

    assign ang_ext = {item.angle_z[15], item.angle_z};
    assign ang_neg = -ang_ext;
    assign in_mag  = item.angle_z[15] ? ang_neg[15:0] : item.angle_z[15:0];
    assign in_hneg = !item.angle_z[15] && (item.angle_z != 16'sd0);
    assign in_dt   = (item.elapsed_ms == 16'd0) ? hpd_pkg::DT_DEFAULT : item.elapsed_ms;

    // ---------------- datapath helpers ----------------
    logic               need_wrap;
    logic [9:0]         wrap_mag;
    logic signed [10:0] wrap_pos, heading_new;
    logic signed [10:0] err_new, err_neg;
    logic [9:0]         err_abs;
    logic signed [11:0] diff, diff_neg;
    logic [10:0]        diff_abs;
    logic signed [31:0] integ_neg;
    logic [31:0]        integ_abs;
    logic signed [33:0] ed, isum;
    logic signed [31:0] integ_sat;
    logic signed [hpd_pkg::SUM_W-1:0] mul_s, quo_s;
    logic unit_done;

    assign need_wrap   = (mag_reg > hpd_pkg::WRAP_DEG);
    // magnitudes past one turn: ((m - 1) mod 360) + 1
    assign wrap_mag    = need_wrap ? (div_rem[9:0] + 10'd1) : mag_reg[9:0];
    assign wrap_pos    = {1'b0, wrap_mag};
    assign heading_new = hneg_reg ? -wrap_pos : wrap_pos;

    assign err_new  = {target_reg[9], target_reg} - heading_reg;
    assign err_neg  = -err_reg;
    assign err_abs  = err_reg[10] ? err_neg[9:0] : err_reg[9:0];

    assign diff     = {err_reg[10], err_reg} - {last_err_reg[10], last_err_reg};
    assign diff_neg = -diff;
    assign diff_abs = diff[11] ? diff_neg[10:0] : diff[10:0];

    assign integ_neg = -integ_reg;
    assign integ_abs = integ_reg[31] ? integ_neg : integ_reg;

    // err * dt with the sign of err, then saturating accumulate
    assign ed   = err_reg[10] ? -$signed({1'b0, mul_prod[32:0]}) : $signed({1'b0, mul_prod[32:0]});
    assign isum = {{2{integ_reg[31]}}, integ_reg} + ed;
    always_comb
    begin
        if (isum > 34'sd2147483647)
            integ_sat = 32'sh7FFFFFFF;
        else if (isum < -34'sd2147483648)
            integ_sat = 32'sh80000000;
        else
            integ_sat = isum[31:0];
    end

    assign mul_s = $signed({1'b0, mul_prod[hpd_pkg::SUM_W-2:0]});
    assign quo_s = $signed({1'b0, div_quo[hpd_pkg::SUM_W-2:0]});

    assign unit_done = (state_reg == hpd_pkg::S_WRAP || state_reg == hpd_pkg::S_DIV_I ||
                        state_reg == hpd_pkg::S_DIV_D) ? div_done : mul_done;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        phase_next = 1'b0;
        unique case (state_reg)
            hpd_pkg::S_IDLE:
                if (item_take)
                    state_next = hpd_pkg::S_WRAP;
            hpd_pkg::S_WRAP:
                if (!need_wrap)
                    state_next = hpd_pkg::S_CHECK;
                else if (!phase_reg)
                    phase_next = 1'b1;
                else if (unit_done)
                    state_next = hpd_pkg::S_CHECK;
                else
                    phase_next = 1'b1;
            hpd_pkg::S_CHECK:
                if (mode_reg == hpd_pkg::MODE_TURN && heading_reg == {target_reg[9], target_reg})
                    state_next = hpd_pkg::S_FIN;
                else
                    state_next = hpd_pkg::S_MUL_ED;
            hpd_pkg::S_MUL_ED, hpd_pkg::S_MUL_P, hpd_pkg::S_MUL_I, hpd_pkg::S_DIV_I,
            hpd_pkg::S_MUL_D, hpd_pkg::S_MUL_K, hpd_pkg::S_DIV_D:
            begin
                if (!phase_reg)
                    phase_next = 1'b1;
                else if (!unit_done)
                    phase_next = 1'b1;
                else
                begin
                    unique case (state_reg)
                        hpd_pkg::S_MUL_ED: state_next = hpd_pkg::S_MUL_P;
                        hpd_pkg::S_MUL_P:  state_next = hpd_pkg::S_MUL_I;
                        hpd_pkg::S_MUL_I:  state_next = hpd_pkg::S_DIV_I;
                        hpd_pkg::S_DIV_I:  state_next = hpd_pkg::S_MUL_D;
                        hpd_pkg::S_MUL_D:  state_next = hpd_pkg::S_MUL_K;
                        hpd_pkg::S_MUL_K:  state_next = hpd_pkg::S_DIV_D;
                        default:           state_next = hpd_pkg::S_SUM;
                    endcase
                end
            end
            hpd_pkg::S_SUM:
                state_next = hpd_pkg::S_FIN;
            hpd_pkg::S_FIN:
                if (fin_load)
                    state_next = hpd_pkg::S_IDLE;
            default:
                state_next = hpd_pkg::S_IDLE;
        endcase
    end

    // ---------------- unit requests ----------------
    always_comb
    begin
        mul_req       = '0;
        div_req       = '0;
        div_req.den   = hpd_pkg::MILLI;
        unique case (state_reg)
            hpd_pkg::S_WRAP:
            begin
                div_req.start = need_wrap && !phase_reg;
                div_req.num   = hpd_pkg::DIV_N_W'(mag_reg - 16'd1);
                div_req.den   = hpd_pkg::WRAP_DEG;
            end
            hpd_pkg::S_MUL_ED:
            begin
                mul_req.start = !phase_reg;
                mul_req.a     = hpd_pkg::MUL_A_W'(err_abs);
                mul_req.b     = hpd_pkg::MUL_B_W'(dt_reg);
            end
            hpd_pkg::S_MUL_P:
            begin
                mul_req.start = !phase_reg;
                mul_req.a     = hpd_pkg::MUL_A_W'(gain_p_reg);
                mul_req.b     = hpd_pkg::MUL_B_W'(err_abs);
            end
            hpd_pkg::S_MUL_I:
            begin
                mul_req.start = !phase_reg;
                mul_req.a     = hpd_pkg::MUL_A_W'(gain_i_reg);
                mul_req.b     = integ_abs;
            end
            hpd_pkg::S_DIV_I:
            begin
                div_req.start = !phase_reg;
                div_req.num   = tmp_reg;
                div_req.den   = hpd_pkg::MILLI;
            end
            hpd_pkg::S_MUL_D:
            begin
                mul_req.start = !phase_reg;
                mul_req.a     = hpd_pkg::MUL_A_W'(gain_d_reg);
                mul_req.b     = hpd_pkg::MUL_B_W'(diff_abs);
            end
            hpd_pkg::S_MUL_K:
            begin
                mul_req.start = !phase_reg;
                mul_req.a     = tmp_reg;
                mul_req.b     = hpd_pkg::MUL_B_W'(hpd_pkg::MILLI);
            end
            hpd_pkg::S_DIV_D:
            begin
                div_req.start = !phase_reg;
                div_req.num   = tmp_reg;
                div_req.den   = dt_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // ---------------- result formatting ----------------
    logic signed [hpd_pkg::SUM_W-1:0] sum_adj;
    logic signed [33:0]               corr_wide;
    logic signed [15:0]               corr;
    logic signed [16:0]               corr_ext, corr_neg;
    logic signed [17:0]               spd18, corr18, v_minus, v_plus, v_mag;
    logic [7:0]                       duty_minus, duty_plus, duty_mag;
    hpd_pkg::result_t                 result_new;

    // divide by 2^16 truncating toward zero
    assign sum_adj   = sum_reg[hpd_pkg::SUM_W-1] ? (sum_reg + 50'sd65535) : sum_reg;
    assign corr_wide = sum_adj[hpd_pkg::SUM_W-1:16];
    always_comb
    begin
        if (corr_wide > 34'sd32767)
            corr = 16'sh7FFF;
        else if (corr_wide < -34'sd32768)
            corr = 16'sh8000;
        else
            corr = corr_wide[15:0];
    end

    assign corr_ext   = {corr[15], corr};
    assign corr_neg   = -corr_ext;
    assign spd18      = $signed({10'd0, speed_reg});
    assign corr18     = {{2{corr[15]}}, corr};
    assign v_minus    = spd18 - corr18;
    assign v_plus     = spd18 + corr18;
    assign v_mag      = spd18 + $signed({1'b0, (corr[15] ? corr_neg : corr_ext)});
    assign duty_minus = hpd_pkg::duty_sat(v_minus);
    assign duty_plus  = hpd_pkg::duty_sat(v_plus);
    assign duty_mag   = hpd_pkg::duty_sat(v_mag);

    always_comb
    begin
        result_new = '0;
        priority if (reached_reg)
        begin
            result_new.motor_forward = hpd_pkg::FWD_ALL;
            result_new.reached       = 1'b1;
        end
        else if (mode_reg == hpd_pkg::MODE_HOLD)
        begin
            result_new.correction    = corr;
            result_new.motor1_duty   = duty_minus;
            result_new.motor2_duty   = duty_plus;
            result_new.motor3_duty   = duty_minus;
            result_new.motor4_duty   = duty_plus;
            result_new.motor_forward = hpd_pkg::FWD_ALL;
        end
        else
        begin
            result_new.correction    = corr;
            result_new.motor1_duty   = duty_mag;
            result_new.motor2_duty   = duty_mag;
            result_new.motor3_duty   = duty_mag;
            result_new.motor4_duty   = duty_mag;
            result_new.motor_forward = (sum_reg > 50'sd0) ? hpd_pkg::FWD_RIGHT : hpd_pkg::FWD_LEFT;
        end
    end

    // ---------------- control and persistent state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hpd_pkg::S_IDLE;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= hpd_pkg::MODE_HOLD;
            target_reg       <= '0;
            speed_reg        <= '0;
            gain_p_reg       <= hpd_pkg::GAIN_P_RST;
            gain_i_reg       <= hpd_pkg::GAIN_I_RST;
            gain_d_reg       <= hpd_pkg::GAIN_D_RST;
            integ_reg        <= '0;
            last_err_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;

            if (fin_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hpd_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                    hpd_pkg::CFG_TARGET: target_reg <= cfg_data[9:0];
                    hpd_pkg::CFG_SPEED:  speed_reg  <= cfg_data[7:0];
                    hpd_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data;
                    hpd_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data;
                    hpd_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data;
                    default:             mode_reg   <= mode_reg;
                endcase
            end

            // restart clears state even when turn mode is already on target
            if (item_take && item.restart)
            begin
                integ_reg    <= '0;
                last_err_reg <= '0;
            end
            else if (state_reg == hpd_pkg::S_MUL_ED && phase_reg && mul_done)
                integ_reg <= integ_sat;

            if (state_reg == hpd_pkg::S_DIV_D && phase_reg && div_done)
                last_err_reg <= err_reg;
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mag_reg     <= in_mag;
            hneg_reg    <= in_hneg;
            dt_reg      <= in_dt;
            reached_reg <= 1'b0;
        end

        if (state_reg == hpd_pkg::S_WRAP && (!need_wrap || (phase_reg && div_done)))
            heading_reg <= heading_new;

        if (state_reg == hpd_pkg::S_CHECK)
        begin
            err_reg     <= err_new;
            reached_reg <= (mode_reg == hpd_pkg::MODE_TURN) &&
                           (heading_reg == {target_reg[9], target_reg});
        end

        if (phase_reg && unit_done)
        begin
            unique case (state_reg)
                hpd_pkg::S_MUL_P: p_reg   <= err_reg[10] ? -mul_s : mul_s;
                hpd_pkg::S_MUL_I: tmp_reg <= mul_prod;
                hpd_pkg::S_DIV_I: i_reg   <= integ_reg[31] ? -quo_s : quo_s;
                hpd_pkg::S_MUL_D: tmp_reg <= mul_prod;
                hpd_pkg::S_MUL_K: tmp_reg <= mul_prod;
                hpd_pkg::S_DIV_D: d_reg   <= diff[11] ? -quo_s : quo_s;
                default:          tmp_reg <= tmp_reg;
            endcase
        end

        if (state_reg == hpd_pkg::S_SUM)
            sum_reg <= p_reg + i_reg + d_reg;

        if (fin_load)
            result_reg <= result_new;
    end

`ifndef SYNTHESIS
    // an on-target turn result always carries stopped motors and no correction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reached |->
            result.correction == 16'sd0 && result.motor1_duty == 8'd0 &&
            result.motor2_duty == 8'd0 && result.motor3_duty == 8'd0 &&
            result.motor4_duty == 8'd0)
        else $error("reached result with nonzero drive");

    // an accepted transaction always starts with the heading wrap step
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg == hpd_pkg::S_WRAP)
        else $error("sequencer did not start on accept");

    // the two serial units never finish in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider overlap");

    // a result waiting on a stalled output keeps the sequencer parked
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hpd_pkg::S_FIN && result_valid_reg && result_stall |=>
            state_reg == hpd_pkg::S_FIN)
        else $error("result register overwritten while stalled");
`endif

endmodule
